@@ design/nnr_pkg.sv @@
// ----------------------------------------------------------------------------
// nnr_pkg
// Shared field widths, distance type and saturation limit for the
// nearest neighbour ranking block.
// ----------------------------------------------------------------------------
package nnr_pkg;

  // Fixed field widths of the stream items
  localparam int IdxWidth     = 6;
  localparam int InCoordWidth = 24;
  localparam int CountWidth   = 7;
  localparam int DistWidth    = 25;

  typedef logic [DistWidth-1:0] dist_t;

  // Largest distance that can be reported; larger values saturate to it
  localparam dist_t DistMax = {DistWidth{1'b1}};

endpackage

@@ design/nnr_sqrt.sv @@
// ----------------------------------------------------------------------------
// nnr_sqrt
// Iterative square root, one result bit per cycle, rounded to the nearest
// integer and saturated to the distance width.
// ----------------------------------------------------------------------------
module nnr_sqrt #(
  parameter int SUM_W = 50
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SUM_W-1:0]   radicand,
  output logic               done,
  output nnr_pkg::dist_t     root_out
);
  import nnr_pkg::*;

  localparam int RW  = SUM_W / 2;
  localparam int CW  = $clog2(RW + 1);
  localparam int EW  = (RW + 1 > DistWidth) ? RW + 1 : DistWidth;

  logic [SUM_W-1:0] sh_r;
  logic [RW+1:0]    rem_r;
  logic [RW-1:0]    root_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [RW+1:0]    rem_t;
  logic [RW+1:0]    trial;
  logic [RW:0]      rnd;
  logic [EW-1:0]    rnd_ext;

  // One digit of the restoring square root recurrence
  assign rem_t = {rem_r[RW-1:0], sh_r[SUM_W-1 -: 2]};
  assign trial = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(RW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r   <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      sh_r <= sh_r << 2;
      if (rem_t >= trial) begin
        rem_r  <= rem_t - trial;
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_t;
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  // Round up when the remainder exceeds the root, then saturate
  assign rnd     = {1'b0, root_r} + ((rem_r > (RW+2)'(root_r)) ? (RW+1)'(1) : (RW+1)'(0));
  assign rnd_ext = EW'(rnd);
  assign root_out = (rnd_ext > EW'(DistMax)) ? DistMax : rnd_ext[DistWidth-1:0];
  assign done     = done_r;

endmodule

@@ design/nearest_neighbor_ranking.sv @@
// Load transaction: the point is written at the accepting edge.
// Query transaction: the query point is read, then each point's distance is computed
// (one bit-serial square root per point), then the selection scans run, plus output
// waits; the next transaction is taken after that.
// Bad query: its result is presented once the output register is free.
// Reset clears control state and sets node_count to 64; memories are not cleared.
// ----------------------------------------------------------------------------
// nearest_neighbor_ranking
// Holds planar points and emits all points in rising distance order from a
// queried point, ties broken by lower index.
// ----------------------------------------------------------------------------
module nearest_neighbor_ranking #(
  parameter int MAX_NODES   = 64,
  parameter int COORD_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: node_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,      // node_count
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,      // point_index[5:0], coord_x[29:6], coord_y[53:30]
  input  logic [0:0]  in_tuser,      // kind
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,     // rank[5:0], neighbor_index[11:6], distance[36:12]
  output logic        out_tlast,     // last
  output logic [0:0]  out_tuser      // bad_index
);
  import nnr_pkg::*;

  localparam int IDXW  = $clog2(MAX_NODES);
  localparam int CNTW  = $clog2(MAX_NODES + 1);
  localparam int SUM_W = 2 * COORD_WIDTH + 2;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_QRD  = 4'd1;
  localparam logic [3:0] ST_PRD  = 4'd2;
  localparam logic [3:0] ST_PDIF = 4'd3;
  localparam logic [3:0] ST_PMUL = 4'd4;
  localparam logic [3:0] ST_PSUM = 4'd5;
  localparam logic [3:0] ST_PSQ  = 4'd6;
  localparam logic [3:0] ST_SCAN = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;
  localparam logic [3:0] ST_BAD  = 4'd9;

  logic [3:0]               state_r;
  logic [CountWidth-1:0]    node_count_r;
  logic [CountWidth-1:0]    n7;
  logic [CNTW-1:0]          n_eff;

  logic [2*COORD_WIDTH-1:0] pt_mem [MAX_NODES];
  logic [2*COORD_WIDTH-1:0] pt_rd_r;
  dist_t                    dist_mem [MAX_NODES];
  dist_t                    dist_rd_r;

  logic signed [COORD_WIDTH-1:0] qx_r, qy_r, px, py, wx, wy;
  logic signed [COORD_WIDTH:0]   dfx, dfy;
  logic [COORD_WIDTH-1:0]        dx_r, dy_r;
  logic [2*COORD_WIDTH-1:0]      sqx_r, sqy_r;
  logic [SUM_W-1:0]              sum;

  logic [IDXW-1:0]          j_r, r_r, best_idx_r, cmp_idx_r;
  logic [CNTW-1:0]          k_r;
  logic                     cmp_vld_r, found_r;
  dist_t                    best_dist_r;
  logic [MAX_NODES-1:0]     taken_r;

  logic                     in_acc, idx_ok, out_free, last_pt;
  logic [IdxWidth-1:0]      in_idx;
  logic                     sq_start, sq_done;
  dist_t                    sq_dist;

  logic                     out_valid_r;
  logic [IdxWidth-1:0]      o_rank_r, o_idx_r;
  dist_t                    o_dist_r;
  logic                     o_last_r, o_bad_r;

  // Effective point count: zero acts as one, large values clamp
  always_comb begin
    n7 = node_count_r;
    if (node_count_r == '0) n7 = CountWidth'(1);
    else if (node_count_r > CountWidth'(MAX_NODES)) n7 = CountWidth'(MAX_NODES);
  end
  assign n_eff = CNTW'(n7);

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) node_count_r <= CountWidth'(64);
    else if (cfg_valid) node_count_r <= cfg_data;
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_idx    = in_tdata[IdxWidth-1:0];
  assign idx_ok    = {1'b0, in_idx} < n7;
  assign wx        = COORD_WIDTH'($signed(in_tdata[29:6]));
  assign wy        = COORD_WIDTH'($signed(in_tdata[53:30]));
  assign out_free  = !out_valid_r || out_tready;
  assign last_pt   = CountWidth'(j_r) == n7 - 1'b1;

  // Point memory: written by loads, read for the query point and each point
  always_ff @(posedge clk) begin
    if (in_acc && !in_tuser[0] && idx_ok) pt_mem[in_idx[IDXW-1:0]] <= {wy, wx};
    if (in_acc) pt_rd_r <= pt_mem[in_idx[IDXW-1:0]];
    else if (state_r == ST_PRD) pt_rd_r <= pt_mem[j_r];
  end
  assign px = pt_rd_r[COORD_WIDTH-1:0];
  assign py = pt_rd_r[2*COORD_WIDTH-1:COORD_WIDTH];

  // Distance memory: written once per point, read during selection scans
  always_ff @(posedge clk) begin
    if (state_r == ST_PSQ && sq_done) dist_mem[j_r] <= sq_dist;
    dist_rd_r <= dist_mem[k_r[IDXW-1:0]];
  end

  // Absolute differences and squares
  assign dfx = {px[COORD_WIDTH-1], px} - {qx_r[COORD_WIDTH-1], qx_r};
  assign dfy = {py[COORD_WIDTH-1], py} - {qy_r[COORD_WIDTH-1], qy_r};
  always_ff @(posedge clk) begin
    if (state_r == ST_QRD) begin
      qx_r <= px;
      qy_r <= py;
    end
    if (state_r == ST_PDIF) begin
      dx_r <= dfx[COORD_WIDTH] ? COORD_WIDTH'(-dfx) : COORD_WIDTH'(dfx);
      dy_r <= dfy[COORD_WIDTH] ? COORD_WIDTH'(-dfy) : COORD_WIDTH'(dfy);
    end
    if (state_r == ST_PMUL) begin
      sqx_r <= dx_r * dx_r;
      sqy_r <= dy_r * dy_r;
    end
  end
  assign sum      = SUM_W'(sqx_r) + SUM_W'(sqy_r);
  assign sq_start = (state_r == ST_PSUM);

  nnr_sqrt #(.SUM_W(SUM_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sum),
    .done     (sq_done),
    .root_out (sq_dist)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
      taken_r   <= '0;
      j_r       <= '0;
      r_r       <= '0;
      k_r       <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_tuser[0]) state_r <= idx_ok ? ST_QRD : ST_BAD;
        end
        ST_QRD: begin
          j_r     <= '0;
          state_r <= ST_PRD;
        end
        ST_PRD:  state_r <= ST_PDIF;
        ST_PDIF: state_r <= ST_PMUL;
        ST_PMUL: state_r <= ST_PSUM;
        ST_PSUM: state_r <= ST_PSQ;
        ST_PSQ: begin
          if (sq_done) begin
            if (last_pt) begin
              r_r     <= '0;
              k_r     <= '0;
              found_r <= 1'b0;
              taken_r <= '0;
              state_r <= ST_SCAN;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= ST_PRD;
            end
          end
        end
        ST_SCAN: begin
          // Issue one read a cycle, compare the entry read the cycle before
          cmp_vld_r <= (k_r < n_eff);
          cmp_idx_r <= k_r[IDXW-1:0];
          if (k_r < n_eff) k_r <= k_r + 1'b1;
          if (cmp_vld_r && !taken_r[cmp_idx_r] &&
              (!found_r || dist_rd_r < best_dist_r)) begin
            found_r     <= 1'b1;
            best_dist_r <= dist_rd_r;
            best_idx_r  <= cmp_idx_r;
          end
          if (k_r == n_eff && !cmp_vld_r) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            taken_r[best_idx_r] <= 1'b1;
            k_r     <= '0;
            found_r <= 1'b0;
            r_r     <= r_r + 1'b1;
            state_r <= (CountWidth'(r_r) == n7 - 1'b1) ? ST_IDLE : ST_SCAN;
          end
        end
        ST_BAD: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free && (state_r == ST_OUT || state_r == ST_BAD)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && state_r == ST_OUT) begin
      o_rank_r <= IdxWidth'(r_r);
      o_idx_r  <= IdxWidth'(best_idx_r);
      o_dist_r <= best_dist_r;
      o_last_r <= (CountWidth'(r_r) == n7 - 1'b1);
      o_bad_r  <= 1'b0;
    end else if (out_free && state_r == ST_BAD) begin
      o_rank_r <= '0;
      o_idx_r  <= '0;
      o_dist_r <= '0;
      o_last_r <= 1'b1;
      o_bad_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, o_dist_r, o_idx_r, o_rank_r};
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_bad_r;

endmodule

@@ verif/nearest_neighbor_ranking_tb.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_ranking_tb
// Self-checking bench for the nearest neighbour ranking block. Points are
// loaded and queried under several point counts, including the extremes and
// out-of-range values. A scoreboard predicts the ranked result transactions
// of every query and checks each result field by field.
// ----------------------------------------------------------------------------
module nearest_neighbor_ranking_tb;
  import nnr_pkg::*;

  typedef enum logic {KIND_LOAD = 1'b0, KIND_QUERY = 1'b1} item_kind_t;

  typedef struct {
    bit [IdxWidth-1:0] rank;
    bit [IdxWidth-1:0] neighbour;
    dist_t             distance;
    bit                last;
    bit                bad_index;
  } ranked_point_t;

  localparam int NodeSlots  = 64;
  localparam int CycleLimit = 20000000;

  // Scoreboard: keeps its own copy of the point store and the point count
  class rank_scoreboard;
    bit [InCoordWidth-1:0] store_x[NodeSlots];
    bit [InCoordWidth-1:0] store_y[NodeSlots];
    int                    node_count;
    ranked_point_t         ranking_q[$];
    int                    errors;

    function new();
      node_count = 64;
      errors     = 0;
    endfunction

    function int active_points();
      if (node_count == 0) return 1;
      if (node_count > NodeSlots) return NodeSlots;
      return node_count;
    endfunction

    function longint unsigned rounded_root(longint unsigned s);
      longint unsigned res, bit_w, rem;
      res = 0;
      rem = s;
      bit_w = 64'd1 << 62;
      while (bit_w > rem) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
        if (rem >= res + bit_w) begin
          rem = rem - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
      if (rem > res) res++;
      return res;
    endfunction

    function dist_t gap_between(int a, int b);
      longint ax, ay, bx, by;
      longint unsigned dx, dy, root;
      ax = longint'($signed(store_x[a]));
      ay = longint'($signed(store_y[a]));
      bx = longint'($signed(store_x[b]));
      by = longint'($signed(store_y[b]));
      dx = (ax >= bx) ? ax - bx : bx - ax;
      dy = (ay >= by) ? ay - by : by - ay;
      root = rounded_root(dx * dx + dy * dy);
      if (root > DistMax) return DistMax;
      return dist_t'(root);
    endfunction

    // Note an accepted input transaction and queue the results it causes
    function void note_item(item_kind_t kind, int idx, bit [InCoordWidth-1:0] x,
                            bit [InCoordWidth-1:0] y);
      int n, r;
      dist_t gaps[NodeSlots];
      ranked_point_t by_rank[NodeSlots];
      ranked_point_t flagged;
      n = active_points();
      if (kind == KIND_LOAD) begin
        if (idx < n) begin
          store_x[idx] = x;
          store_y[idx] = y;
        end
        return;
      end
      if (idx >= n) begin
        flagged = '{'0, '0, '0, 1'b1, 1'b1};
        ranking_q.insert(ranking_q.size(), flagged);
        return;
      end
      for (int j = 0; j < n; j++) gaps[j] = gap_between(idx, j);
      for (int j = 0; j < n; j++) begin
        r = 0;
        for (int k = 0; k < n; k++)
          if (gaps[k] < gaps[j] || (gaps[k] == gaps[j] && k < j)) r++;
        by_rank[r] = '{IdxWidth'(r), IdxWidth'(j), gaps[j], r == n - 1, 1'b0};
      end
      for (int j = 0; j < n; j++) ranking_q.insert(ranking_q.size(), by_rank[j]);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Compare one result transaction with the oldest expectation
    task check_result(bit [39:0] data, bit last, bit bad);
      ranked_point_t got, want;
      got = '{data[5:0], data[11:6], data[36:12], last, bad};
      if (ranking_q.size() == 0) begin
        report($sformatf("unexpected result rank %0d neighbour %0d",
                         got.rank, got.neighbour));
        return;
      end
      want = ranking_q.pop_front();
      if (got.rank != want.rank)
        report($sformatf("rank %0d, want %0d", got.rank, want.rank));
      if (got.neighbour != want.neighbour)
        report($sformatf("neighbour %0d, want %0d (rank %0d)", got.neighbour,
                         want.neighbour, want.rank));
      if (got.distance != want.distance)
        report($sformatf("distance %0d, want %0d (rank %0d)", got.distance,
                         want.distance, want.rank));
      if (got.last != want.last)
        report($sformatf("last %0b, want %0b (rank %0d)", got.last, want.last,
                         want.rank));
      if (got.bad_index != want.bad_index)
        report($sformatf("bad_index %0b, want %0b", got.bad_index, want.bad_index));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // point_index, coord_x, coord_y
  logic [0:0]  in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // rank, neighbor_index, distance
  logic        out_tlast;  // last
  logic [0:0]  out_tuser;  // bad_index

  rank_scoreboard ranking_sb;
  int  burst_left;
  int  cycles;
  bit  hold_off_req;
  int  hold_left;
  int  stall_phase;
  bit  stall_busy;

  nearest_neighbor_ranking dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog against a hung block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: a long hold-off on request, otherwise alternating calm and choppy spells
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_off_req) begin
      hold_off_req <= 1'b0;
      hold_left    <= 600;
      out_tready   <= 1'b0;
    end else begin
      stall_phase <= (stall_phase == 0) ? $urandom_range(50, 300) : stall_phase - 1;
      if (stall_phase == 0) stall_busy <= ~stall_busy;
      out_tready <= stall_busy ? ($urandom_range(0, 9) < 6) : 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      ranking_sb.check_result(out_tdata, out_tlast, out_tuser[0]);
  end

  function bit [InCoordWidth-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2, 3: return InCoordWidth'($urandom_range(0, 15) - 8);
      default: return InCoordWidth'($urandom);
    endcase
  endfunction

  task send_item(item_kind_t kind, int idx, bit [InCoordWidth-1:0] x,
                 bit [InCoordWidth-1:0] y);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 5);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, y, x, 6'(idx)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ranking_sb.note_item(kind, idx, x, y);
    burst_left--;
  endtask

  // Let every expected result arrive and the block settle
  task drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ranking_sb.ranking_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task write_node_count(int value);
    cfg_valid <= 1'b1;
    cfg_data  <= 7'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ranking_sb.node_count = value;
  endtask

  // One phase: fill every active point, then a random mix of loads and queries
  task run_phase(int count, int extra, int query_pct);
    int n, idx;
    drain();
    write_node_count(count);
    n = ranking_sb.active_points();
    for (int i = 0; i < n; i++) send_item(KIND_LOAD, i, pick_coord(), pick_coord());
    for (int i = 0; i < extra; i++) begin
      if ($urandom_range(0, 99) < query_pct) begin
        if (n < NodeSlots && $urandom_range(0, 6) == 0) idx = $urandom_range(n, 63);
        else idx = $urandom_range(0, n - 1);
        send_item(KIND_QUERY, idx, pick_coord(), pick_coord());
      end else begin
        idx = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
        send_item(KIND_LOAD, idx, pick_coord(), pick_coord());
      end
    end
  endtask

  initial begin
    ranking_sb   = new();
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = KIND_LOAD;
    cycles       = 0;
    burst_left   = 0;
    hold_off_req = 1'b0;
    hold_left    = 0;
    stall_phase  = 0;
    stall_busy   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: four points with extreme corners, a tie and the origin
    write_node_count(4);
    send_item(KIND_LOAD, 0, 24'h800000, 24'h800000);
    send_item(KIND_LOAD, 1, 24'h7fffff, 24'h7fffff);
    send_item(KIND_LOAD, 2, 24'h800000, 24'h800000);
    send_item(KIND_LOAD, 3, 24'h000000, 24'h000000);
    send_item(KIND_LOAD, 4, 24'h123456, 24'h654321);   // beyond the count, ignored
    send_item(KIND_LOAD, 63, 24'h7fffff, 24'h800000);  // beyond the count, ignored
    for (int i = 0; i < 4; i++) send_item(KIND_QUERY, i, 24'h7fffff, 24'h800000);
    send_item(KIND_QUERY, 4, 24'h0, 24'h0);
    send_item(KIND_QUERY, 63, 24'hffffff, 24'hffffff);
    send_item(KIND_LOAD, 3, 24'h7fffff, 24'h800000);
    send_item(KIND_QUERY, 3, 24'h0, 24'h0);

    // Results held back for a long spell while queries keep coming
    drain();
    hold_off_req = 1'b1;
    for (int i = 0; i < 12; i++) send_item(KIND_QUERY, $urandom_range(0, 5), 24'h0, 24'h0);

    run_phase(1, 35, 40);
    run_phase(0, 35, 40);
    run_phase(8, 35, 35);
    run_phase(127, 10, 25);
    run_phase(3, 35, 40);
    run_phase(64, 10, 25);
    run_phase(100, 8, 25);
    run_phase(12, 35, 30);
    run_phase(2, 35, 40);

    drain();
    if (ranking_sb.errors == 0 && ranking_sb.ranking_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
